>>> rtl/composite_bounding_sphere_assert.svh
// Assertion macros for the composite bounding sphere block.
`ifndef COMPOSITE_BOUNDING_SPHERE_ASSERT_SVH
`define COMPOSITE_BOUNDING_SPHERE_ASSERT_SVH
`define CBS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Types and constants for the composite bounding sphere block.
// ----------------------------------------------------------------------------
package cbs_pkg;
   localparam int CFG_AW = 4;
   localparam logic [1:0] CFG_OFS_X = 2'd0;
   localparam logic [1:0] CFG_OFS_Y = 2'd1;
   localparam logic [1:0] CFG_OFS_Z = 2'd2;
   localparam logic [1:0] KIND_BOX = 2'd0;
   localparam logic [1:0] KIND_SPHERE = 2'd1;
   localparam logic [1:0] KIND_CYL = 2'd2;
   localparam logic [1:0] KIND_CAPSULE = 2'd3;

   typedef struct packed {
      logic [1:0]         shape_kind;
      logic [30:0]        dim_a;
      logic [30:0]        dim_b;
      logic [30:0]        dim_c;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic               last_shape;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sphere_x;
      logic signed [31:0] sphere_y;
      logic signed [31:0] sphere_z;
      logic [30:0]        sphere_radius;
      logic               overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQA, ST_SQB, ST_SQC, ST_ROOT, ST_STORE,
      ST_DIV, ST_RD, ST_RDW, ST_DX, ST_DY, ST_DZ, ST_DROOT, ST_DCMP, ST_OUT
   } state_type;
endpackage

>>> rtl/cbs_ram.sv
// ----------------------------------------------------------------------------
// cbs_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module cbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> rtl/cbs_isqrt.sv
// ----------------------------------------------------------------------------
// cbs_isqrt
// Integer square root of a 66-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module cbs_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] radicand,
   output logic        done,
   output logic [32:0] root
);
   logic [65:0] rem_ff, rem_in;
   logic [32:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [67:0] trial;

   always_comb begin
      trial = 68'({2'b00, q_ff, 2'b01}) << (2 * cnt_ff);
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done = 1'b0;
      if (start) begin
         rem_in = radicand;
         q_in = '0;
         cnt_in = 6'd32;
         run_in = 1'b1;
      end else if (run_ff) begin
         if ({2'b00, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[65:0];
            q_in = {q_ff[31:0], 1'b1};
         end else begin
            q_in = {q_ff[31:0], 1'b0};
         end
         if (cnt_ff == 6'd0) begin
            run_in = 1'b0;
            done = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end
   assign root = q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
   end
endmodule

>>> rtl/composite_bounding_sphere.sv
// ----------------------------------------------------------------------------
// composite_bounding_sphere
// Bounding sphere of a composition of primitives, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Channel  Ports                      Handshake
// req      req_start/req_busy/req_item accepted when start and not busy
// rsp      rsp_valid/rsp_item          one-cycle strobe, cannot be stalled
// csr      csr_psel ... csr_prdata     APB, pready always high
// An item is accepted only when the block is idle again after the previous
// item's squares, bit-serial square root and store.
// A last item then adds the three divisions, a distance root per stored
// primitive and a final step that forms the result.
// The receiver cannot stall, so a result never holds back the input.
// Reset is synchronous and clears control.
module composite_bounding_sphere #(
   parameter int MAX_SHAPES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   output logic                   req_busy,
   input  cbs_pkg::req_type       req_item,
   output logic                   rsp_valid,
   output cbs_pkg::rsp_type       rsp_item,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [cbs_pkg::CFG_AW-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import cbs_pkg::*;
   localparam int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
   localparam int CW = $clog2(MAX_SHAPES + 1);

   state_type state_ff, state_in;
   logic [31:0] ofs_ff [3];
   req_type item_ff, item_in;
   logic signed [39:0] sum_ff [3];
   logic signed [39:0] sum_in [3];
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic drop_ff, drop_in;
   logic [65:0] acc_ff, acc_in;
   logic [33:0] rad_ff, rad_in;
   logic [33:0] best_ff, best_in;
   logic far_ff, far_in;
   logic signed [31:0] mean_ff [3];
   logic signed [31:0] mean_in [3];
   logic [1:0] axis_ff, axis_in;
   logic [39:0] dq_ff, dq_in;
   logic [39:0] dr_ff, dr_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic dneg_ff, dneg_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic sq_start, sq_done;
   logic [65:0] sq_arg;
   logic [32:0] sq_root;
   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [127:0] ram_wdata, ram_rdata;
   logic [32:0] mul_a;
   logic [65:0] mul_p;
   logic signed [32:0] diff;
   logic [32:0] adiff;
   logic [40:0] dtrial;
   logic signed [33:0] cen;
   logic ovf;
   logic cfg_we;
   logic [1:0] cfg_idx;

   cbs_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_arg),
      .done(sq_done), .root(sq_root)
   );

   cbs_ram #(.WIDTH(128), .DEPTH(MAX_SHAPES)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   assign cfg_we = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00 && cfg_idx <= CFG_OFS_Z) begin
         csr_prdata = ofs_ff[cfg_idx];
      end
   end

   assign mul_p = {33'd0, mul_a} * {33'd0, mul_a};
   assign req_busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      drop_in = drop_ff;
      acc_in = acc_ff;
      rad_in = rad_ff;
      best_in = best_ff;
      far_in = far_ff;
      mean_in = mean_ff;
      axis_in = axis_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      dcnt_in = dcnt_ff;
      dneg_in = dneg_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      sq_start = 1'b0;
      sq_arg = acc_ff;
      ram_we = 1'b0;
      ram_addr = idx_ff;
      ram_wdata = {item_ff.center_x, item_ff.center_y, item_ff.center_z, rad_ff[31:0]};
      mul_a = '0;
      diff = '0;
      adiff = '0;
      dtrial = '0;
      cen = '0;
      ovf = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               item_in = req_item;
               acc_in = '0;
               state_in = ST_SQA;
            end
         end
         ST_SQA: begin
            mul_a = {2'b00, item_ff.dim_a};
            acc_in = (item_ff.shape_kind == KIND_CYL) ? {mul_p[64:0], 1'b0} : mul_p;
            state_in = ST_SQB;
         end
         ST_SQB: begin
            mul_a = {2'b00, item_ff.dim_b};
            acc_in = acc_ff + mul_p;
            state_in = ST_SQC;
         end
         ST_SQC: begin
            mul_a = {2'b00, item_ff.dim_c};
            if (item_ff.shape_kind == KIND_BOX) begin
               acc_in = acc_ff + mul_p;
            end
            sq_start = 1'b1;
            sq_arg = acc_in;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sq_done) begin
               unique case (item_ff.shape_kind)
                  KIND_SPHERE: rad_in = {3'd0, item_ff.dim_a};
                  KIND_CAPSULE: rad_in = {1'b0, ({2'b00, item_ff.dim_b}
                     + {1'b0, item_ff.dim_a, 1'b0}) >> 1};
                  default: rad_in = {2'd0, sq_root[32:1]};
               endcase
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (count_ff < CW'(MAX_SHAPES)) begin
               ram_we = 1'b1;
               ram_addr = AW'(count_ff);
               sum_in[0] = sum_ff[0] + 40'(item_ff.center_x);
               sum_in[1] = sum_ff[1] + 40'(item_ff.center_y);
               sum_in[2] = sum_ff[2] + 40'(item_ff.center_z);
               count_in = count_ff + CW'(1);
            end else begin
               drop_in = 1'b1;
            end
            if (item_ff.last_shape) begin
               axis_in = 2'd0;
               dneg_in = sum_in[0][39];
               dq_in = sum_in[0][39] ? 40'(-sum_in[0]) : sum_in[0];
               dr_in = '0;
               dcnt_in = 6'd39;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // Restoring division of |sum| by the count, one bit a cycle.
            dtrial = {dr_ff, dq_ff[39]} - {{(41 - CW) {1'b0}}, (count_ff == '0) ? CW'(1) : count_ff};
            if (!dtrial[40]) begin
               dr_in = dtrial[39:0];
               dq_in = {dq_ff[38:0], 1'b1};
            end else begin
               dr_in = {dr_ff[38:0], dq_ff[39]};
               dq_in = {dq_ff[38:0], 1'b0};
            end
            if (dcnt_ff == 6'd0) begin
               mean_in[axis_ff] = dneg_ff ? 32'(-dq_in) : dq_in[31:0];
               if (axis_ff == 2'd2) begin
                  idx_in = '0;
                  best_in = '0;
                  state_in = (count_ff == '0) ? ST_OUT : ST_RD;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  dneg_in = sum_ff[axis_ff + 2'd1][39];
                  dq_in = sum_ff[axis_ff + 2'd1][39] ? 40'(-sum_ff[axis_ff + 2'd1])
                     : sum_ff[axis_ff + 2'd1];
                  dr_in = '0;
                  dcnt_in = 6'd39;
               end
            end else begin
               dcnt_in = dcnt_ff - 6'd1;
            end
         end
         ST_RD: state_in = ST_RDW;
         ST_RDW: begin
            rad_in = {2'd0, ram_rdata[31:0]};
            diff = 33'(mean_ff[0]) - 33'($signed(ram_rdata[127:96]));
            adiff = diff[32] ? 33'(-diff) : diff;
            far_in = adiff[32] || adiff[31];
            mul_a = adiff;
            acc_in = mul_p;
            state_in = ST_DY;
         end
         ST_DY: begin
            diff = 33'(mean_ff[1]) - 33'($signed(ram_rdata[95:64]));
            adiff = diff[32] ? 33'(-diff) : diff;
            far_in = far_ff || adiff[32] || adiff[31];
            mul_a = adiff;
            acc_in = acc_ff + mul_p;
            state_in = ST_DZ;
         end
         ST_DZ: begin
            diff = 33'(mean_ff[2]) - 33'($signed(ram_rdata[63:32]));
            adiff = diff[32] ? 33'(-diff) : diff;
            far_in = far_ff || adiff[32] || adiff[31];
            mul_a = adiff;
            acc_in = acc_ff + mul_p;
            sq_start = 1'b1;
            sq_arg = acc_in;
            state_in = ST_DROOT;
         end
         ST_DROOT: begin
            if (sq_done) begin
               rad_in = far_ff ? 34'h080000000 : 34'(sq_root) + rad_ff;
               state_in = ST_DCMP;
            end
         end
         ST_DCMP: begin
            if (rad_ff > best_ff) begin
               best_in = rad_ff;
            end
            if (CW'(idx_ff) + CW'(1) >= count_ff) begin
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + AW'(1);
               state_in = ST_RD;
            end
         end
         ST_OUT: begin
            ovf = drop_ff;
            if (best_ff > 34'h07fffffff) begin
               rsp_in.sphere_radius = 31'h7fffffff;
               ovf = 1'b1;
            end else begin
               rsp_in.sphere_radius = best_ff[30:0];
            end
            for (int k = 0; k < 3; k++) begin
               cen = 34'(mean_ff[k]) + 34'($signed(ofs_ff[k]));
               if (cen > 34'sh07fffffff) begin
                  mean_in[k] = 32'h7fffffff;
                  ovf = 1'b1;
               end else if (cen < -34'sh080000000) begin
                  mean_in[k] = 32'h80000000;
                  ovf = 1'b1;
               end else begin
                  mean_in[k] = cen[31:0];
               end
            end
            rsp_in.sphere_x = mean_in[0];
            rsp_in.sphere_y = mean_in[1];
            rsp_in.sphere_z = mean_in[2];
            rsp_in.overflow = ovf;
            rsp_valid_in = 1'b1;
            sum_in[0] = '0;
            sum_in[1] = '0;
            sum_in[2] = '0;
            count_in = '0;
            drop_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         drop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
            ofs_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff <= sum_in;
         if (cfg_we && csr_paddr[1:0] == 2'b00 && cfg_idx <= CFG_OFS_Z) begin
            ofs_ff[cfg_idx] <= csr_pwdata;
         end
      end
      item_ff <= item_in;
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      rad_ff <= rad_in;
      best_ff <= best_in;
      far_ff <= far_in;
      mean_ff <= mean_in;
      axis_ff <= axis_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      dcnt_ff <= dcnt_in;
      dneg_ff <= dneg_in;
      rsp_ff <= rsp_in;
   end
endmodule

>>> rtl/cbs_checker.sv
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks for the composite bounding sphere block.
// ----------------------------------------------------------------------------
`include "composite_bounding_sphere_assert.svh"
module cbs_checker (
   input logic clock,
   input logic reset,
   input logic req_start,
   input logic req_busy,
   input logic rsp_valid,
   input logic csr_pready
);
   `CBS_ASSERT_NEXT(a_busy_after_start, clock, reset, req_start && !req_busy, req_busy)
   `CBS_ASSERT_IMPL(a_no_rsp_when_idle, clock, reset, rsp_valid, !req_busy)
   `CBS_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `CBS_ASSERT_IMPL(a_pready_high, clock, reset, 1'b1, csr_pready)
endmodule

bind composite_bounding_sphere cbs_checker u_cbs_checker (
   .clock(clock), .reset(reset), .req_start(req_start), .req_busy(req_busy),
   .rsp_valid(rsp_valid), .csr_pready(csr_pready)
);
